### rtl/npc_pkg.sv
// Shared types, constants and helpers for the nearest palette colour unit.
`default_nettype none

package npc_pkg;

	localparam int STORE_DEPTH  = 64;
	localparam int PALETTE_SIZE = 64;
	// Entries 1 .. SEARCH_LIMIT-1 take part in a search.
	localparam int SEARCH_LIMIT = (PALETTE_SIZE > STORE_DEPTH) ? STORE_DEPTH : PALETTE_SIZE;

	localparam int IDX_W   = 6;
	localparam int COMP_W  = 8;
	localparam int SQ_W    = 2 * COMP_W;
	localparam int DIST_W  = 18;
	localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 256 * 3);

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	typedef struct packed {
		logic [DIST_W-1:0] sq_dist;
		logic [IDX_W-1:0]  idx;
	} leaf_t;

	function automatic logic [COMP_W-1:0] abs_diff(input logic [COMP_W-1:0] a,
	                                               input logic [COMP_W-1:0] b);
		logic [COMP_W-1:0] d;
		d = (a > b) ? (a - b) : (b - a);
		return d;
	endfunction

	// The right-hand leaf wins only on a strictly smaller distance, so on a tie
	// the lower index is kept.
	function automatic leaf_t merge(input leaf_t lo, input leaf_t hi);
		leaf_t r;
		r = (hi.sq_dist < lo.sq_dist) ? hi : lo;
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/nearest_palette_color_unit.sv
// Top level of the nearest palette colour unit: palette registers and search pipeline.
// Usage:
//   The slave channel carries load items (tuser low) that write one palette entry
//   and pixel items (tuser high) that are classified. A load gives no result; a
//   pixel gives one item on the master channel holding the index of the nearest
//   palette entry by squared RGB distance, lowest index on a tie, or 0 when the
//   pixel's alpha is 0. Entry 0 is never searched.
//   Throughput is one item per cycle on either channel while the master channel
//   is not stalled. A pixel reaches the master channel through one stage
//   of absolute differences, one of squares, one of sums, three stages of the
//   64-leaf minimum tree (two tree levels each) and the output register.
//   A load takes effect for every pixel accepted after it.
//   When the receiver stalls, the pipeline closes up its bubbles and then holds
//   every stage; s_tready falls only once all stages and the output are full.
//   Reset clears the palette to all zeros and empties the pipeline.
`default_nettype none

module nearest_palette_color_unit (
	input  wire  logic                            clk,
	input  wire  logic                            arst_n,
	input  wire  logic                            s_tvalid,
	output       logic                            s_tready,
	// entry_index[5:0], red[13:6], green[21:14], blue[29:22], alpha[37:30], zero fill
	input  wire  logic [npc_pkg::IN_DATA_W-1:0]   s_tdata,
	// kind[0]
	input  wire  logic                            s_tuser,
	output       logic                            m_tvalid,
	input  wire  logic                            m_tready,
	// color_index[5:0], zero fill
	output       logic [npc_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import npc_pkg::*;

	logic [IDX_W-1:0]  in_idx;
	logic [COMP_W-1:0] in_red, in_green, in_blue, in_alpha;
	logic              in_acc, pix_acc, load_acc;

	logic [3*COMP_W-1:0] pal_q [STORE_DEPTH];

	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_o;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic tr_s1, tr_s2, tr_s3, tr_s4, tr_s5, tr_s6;

	logic [COMP_W-1:0] ad_s1 [STORE_DEPTH][3];
	logic [SQ_W-1:0]   sq_s2 [STORE_DEPTH][3];
	leaf_t             lf_s3 [STORE_DEPTH];
	leaf_t             tr4_s4 [STORE_DEPTH/4];
	leaf_t             tr5_s5 [STORE_DEPTH/16];
	leaf_t             best_s6;
	logic [IDX_W-1:0]  color_index_q;

	leaf_t leaf_c  [STORE_DEPTH];
	leaf_t l1_c    [STORE_DEPTH/2];
	leaf_t l2_c    [STORE_DEPTH/4];
	leaf_t l3_c    [STORE_DEPTH/8];
	leaf_t l4_c    [STORE_DEPTH/16];
	leaf_t l5_c    [STORE_DEPTH/32];
	leaf_t l6_c;

	assign in_idx   = s_tdata[5:0];
	assign in_red   = s_tdata[13:6];
	assign in_green = s_tdata[21:14];
	assign in_blue  = s_tdata[29:22];
	assign in_alpha = s_tdata[37:30];

	// A stage moves on when it is empty or the stage after it moves on.
	assign en_o  = !m_tvalid || m_tready;
	assign en_s6 = !v_s6 || en_o;
	assign en_s5 = !v_s5 || en_s6;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign s_tready = en_s1;
	assign in_acc   = s_tvalid && s_tready;
	assign pix_acc  = in_acc && (s_tuser == KIND_PIXEL);
	assign load_acc = in_acc && (s_tuser == KIND_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++) begin
				pal_q[i] <= '0;
			end
		end else if (load_acc) begin
			pal_q[in_idx] <= {in_red, in_green, in_blue};
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= pix_acc;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
			if (en_s6) v_s6 <= v_s5;
			if (en_o)  m_tvalid <= v_s6;
		end
	end

	// Differences are taken against the palette as it stands when the pixel is
	// accepted, so later loads never reach a pixel already in flight.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			tr_s1 <= (in_alpha == '0);
			for (int i = 0; i < STORE_DEPTH; i++) begin
				ad_s1[i][0] <= abs_diff(in_red,   pal_q[i][23:16]);
				ad_s1[i][1] <= abs_diff(in_green, pal_q[i][15:8]);
				ad_s1[i][2] <= abs_diff(in_blue,  pal_q[i][7:0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			tr_s2 <= tr_s1;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				for (int c = 0; c < 3; c++) begin
					sq_s2[i][c] <= ad_s1[i][c] * ad_s1[i][c];
				end
			end
		end
	end

	// Entry 0 and entries past the palette size get the start distance, which
	// no searched entry can lose to.
	always_comb begin
		for (int i = 0; i < STORE_DEPTH; i++) begin
			if (i >= 1 && i < SEARCH_LIMIT) begin
				leaf_c[i].sq_dist = DIST_W'(sq_s2[i][0]) + DIST_W'(sq_s2[i][1])
				                  + DIST_W'(sq_s2[i][2]);
				leaf_c[i].idx     = IDX_W'(i);
			end else begin
				leaf_c[i].sq_dist = DIST_START;
				leaf_c[i].idx     = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			tr_s3 <= tr_s2;
			for (int i = 0; i < STORE_DEPTH; i++) begin
				lf_s3[i] <= leaf_c[i];
			end
		end
	end

	// Minimum tree, two levels per stage.
	always_comb begin
		for (int j = 0; j < STORE_DEPTH/2; j++)  l1_c[j] = merge(lf_s3[2*j], lf_s3[2*j+1]);
		for (int j = 0; j < STORE_DEPTH/4; j++)  l2_c[j] = merge(l1_c[2*j], l1_c[2*j+1]);
		for (int j = 0; j < STORE_DEPTH/8; j++)  l3_c[j] = merge(tr4_s4[2*j], tr4_s4[2*j+1]);
		for (int j = 0; j < STORE_DEPTH/16; j++) l4_c[j] = merge(l3_c[2*j], l3_c[2*j+1]);
		for (int j = 0; j < STORE_DEPTH/32; j++) l5_c[j] = merge(tr5_s5[2*j], tr5_s5[2*j+1]);
		l6_c = merge(l5_c[0], l5_c[1]);
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			tr_s4 <= tr_s3;
			for (int j = 0; j < STORE_DEPTH/4; j++) tr4_s4[j] <= l2_c[j];
		end
		if (en_s5) begin
			tr_s5 <= tr_s4;
			for (int j = 0; j < STORE_DEPTH/16; j++) tr5_s5[j] <= l4_c[j];
		end
		if (en_s6) begin
			tr_s6   <= tr_s5;
			best_s6 <= l6_c;
		end
		if (en_o) begin
			color_index_q <= tr_s6 ? '0 : best_s6.idx;
		end
	end

	assign m_tdata = {{(OUT_DATA_W-IDX_W){1'b0}}, color_index_q};

`ifndef SYNTHESIS
	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(color_index_q) < SEARCH_LIMIT) || (color_index_q == '0))
		else $error("result index outside the searched palette");

	a_opaque_finds_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !tr_s6 && (SEARCH_LIMIT > 1)) |-> (best_s6.idx != '0))
		else $error("opaque pixel found no palette entry");

	a_held_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s6 && !en_s6) |=> (v_s6 && $stable(best_s6) && $stable(tr_s6)))
		else $error("stalled last stage changed");

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready && v_s1 && v_s6))
		else $error("input blocked while the pipeline has room");
`endif

endmodule

`default_nettype wire
